// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked including reset cycles
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/ptob_pkg.sv -----
// ----------------------------------------------------------------------------
// ptob_pkg
// shared types and constants of the order book matcher
// ----------------------------------------------------------------------------
package ptob_pkg;

   localparam int LEVELS_DEF = 8;
   localparam int ORDERS_DEF = 8;
   localparam int PRICE_BITS_DEF = 32;
   localparam int QTY_BITS_DEF = 32;
   localparam int MAX_FILLS = 64;
   localparam int ID_BITS = 64;
   localparam int OUT_PX_BITS = 32;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_QTY   = 3'd1,
      ST_BAD_PRICE = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // command from the controller to every level cell
   typedef enum logic [2:0] {
      LC_NONE   = 3'd0,
      LC_POP    = 3'd1,  // level at a position shifts out, deeper ones move up
      LC_INSERT = 3'd2,  // open a new level at a position, lower ones move down
      LC_APPEND = 3'd3,  // push an order into one level
      LC_FILL   = 3'd4,  // reduce the head order of the best level
      LC_HEAD   = 3'd5,  // drop the head order of the best level
      LC_REMOVE = 3'd6   // remove an order at a position of one level
   } lvl_cmd_type;

endpackage

// ----- hdl/ptob_order_cell.sv -----
// ----------------------------------------------------------------------------
// ptob_order_cell
// one slot of a level fifo: holds an order id and its remaining lots
// ----------------------------------------------------------------------------
module ptob_order_cell #(
   parameter int QTY_BITS = ptob_pkg::QTY_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [ptob_pkg::ID_BITS-1:0] id_in,
   input  logic [QTY_BITS-1:0]          qty_in,
   output logic [ptob_pkg::ID_BITS-1:0] id_out,
   output logic [QTY_BITS-1:0]          qty_out
);
   import ptob_pkg::*;

   logic [ID_BITS-1:0]  id_ff;
   logic [QTY_BITS-1:0] qty_ff;

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         id_ff  <= id_in;
         qty_ff <= qty_in;
      end
   end

   assign id_out  = id_ff;
   assign qty_out = qty_ff;

endmodule

// ----- hdl/ptob_level_cell.sv -----
// ----------------------------------------------------------------------------
// ptob_level_cell
// one price level: price and an ordered row of order cells, head at slot 0;
// takes its whole content from a neighbor level on shifts
// ----------------------------------------------------------------------------
module ptob_level_cell #(
   parameter int ORDERS     = ptob_pkg::ORDERS_DEF,
   parameter int PRICE_BITS = ptob_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = ptob_pkg::QTY_BITS_DEF,
   localparam int FILL_BITS = $clog2(ORDERS + 1),
   localparam int POS_BITS  = $clog2(ORDERS)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ptob_pkg::lvl_cmd_type                 cmd,
   input  logic                                  from_up,   // take content of level above
   input  logic                                  from_down, // take content of level below
   input  logic                                  sel,       // this level is the target
   input  logic [POS_BITS-1:0]                   pos,
   input  logic [PRICE_BITS-1:0]                 new_price,
   input  logic [ptob_pkg::ID_BITS-1:0]          new_id,
   input  logic [QTY_BITS-1:0]                   new_qty,
   // neighbor content
   input  logic [PRICE_BITS-1:0]                 up_price,
   input  logic [FILL_BITS-1:0]                  up_fill,
   input  logic [ORDERS-1:0][ptob_pkg::ID_BITS-1:0] up_ids,
   input  logic [ORDERS-1:0][QTY_BITS-1:0]       up_qtys,
   input  logic [PRICE_BITS-1:0]                 dn_price,
   input  logic [FILL_BITS-1:0]                  dn_fill,
   input  logic [ORDERS-1:0][ptob_pkg::ID_BITS-1:0] dn_ids,
   input  logic [ORDERS-1:0][QTY_BITS-1:0]       dn_qtys,
   output logic [PRICE_BITS-1:0]                 price,
   output logic [FILL_BITS-1:0]                  fill,
   output logic [ORDERS-1:0][ptob_pkg::ID_BITS-1:0] ids,
   output logic [ORDERS-1:0][QTY_BITS-1:0]       qtys
);
   import ptob_pkg::*;

   logic [PRICE_BITS-1:0] price_ff;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [ORDERS-1:0]     ld;
   logic [ORDERS-1:0][ID_BITS-1:0]  id_d;
   logic [ORDERS-1:0][QTY_BITS-1:0] qty_d;

   // per-slot next content
   always_comb begin
      for (int k = 0; k < ORDERS; k++) begin
         ld[k]    = 1'b0;
         id_d[k]  = ids[k];
         qty_d[k] = qtys[k];
         if (from_up) begin
            ld[k] = 1'b1; id_d[k] = up_ids[k]; qty_d[k] = up_qtys[k];
         end else if (from_down) begin
            ld[k] = 1'b1; id_d[k] = dn_ids[k]; qty_d[k] = dn_qtys[k];
         end else if (sel) begin
            unique case (cmd)
               LC_INSERT: begin
                  if (k == 0) begin
                     ld[k] = 1'b1; id_d[k] = new_id; qty_d[k] = new_qty;
                  end
               end
               LC_APPEND: begin
                  if (FILL_BITS'(k) == fill_ff) begin
                     ld[k] = 1'b1; id_d[k] = new_id; qty_d[k] = new_qty;
                  end
               end
               LC_FILL: begin
                  if (k == 0) begin
                     ld[k] = 1'b1; qty_d[k] = new_qty;
                  end
               end
               LC_HEAD: begin
                  if (k + 1 < ORDERS) begin
                     ld[k] = 1'b1; id_d[k] = ids[k + 1]; qty_d[k] = qtys[k + 1];
                  end
               end
               LC_REMOVE: begin
                  if (k + 1 < ORDERS && k >= int'(pos)) begin
                     ld[k] = 1'b1; id_d[k] = ids[k + 1]; qty_d[k] = qtys[k + 1];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // fill count
   always_comb begin
      fill_in = fill_ff;
      if (from_up)        fill_in = up_fill;
      else if (from_down) fill_in = dn_fill;
      else if (sel) begin
         unique case (cmd)
            LC_INSERT:            fill_in = FILL_BITS'(1);
            LC_APPEND:            fill_in = fill_ff + FILL_BITS'(1);
            LC_HEAD, LC_REMOVE:   fill_in = fill_ff - FILL_BITS'(1);
            default:              fill_in = fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else       fill_ff <= fill_in;
   end

   always_ff @(posedge clock) begin
      if (from_up)        price_ff <= up_price;
      else if (from_down) price_ff <= dn_price;
      else if (sel && cmd == LC_INSERT) price_ff <= new_price;
   end

   genvar g;
   generate
      for (g = 0; g < ORDERS; g++) begin : g_slot
         ptob_order_cell #(.QTY_BITS(QTY_BITS)) u_slot (
            .clock  (clock),
            .load   (ld[g]),
            .id_in  (id_d[g]),
            .qty_in (qty_d[g]),
            .id_out (ids[g]),
            .qty_out(qtys[g])
         );
      end
   endgenerate

   assign price = price_ff;
   assign fill  = fill_ff;

endmodule

// ----- hdl/ptob_side.sv -----
// ----------------------------------------------------------------------------
// ptob_side
// one side of the book: a chain of level cells sorted best first
// ----------------------------------------------------------------------------
module ptob_side #(
   parameter int LEVELS     = ptob_pkg::LEVELS_DEF,
   parameter int ORDERS     = ptob_pkg::ORDERS_DEF,
   parameter int PRICE_BITS = ptob_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = ptob_pkg::QTY_BITS_DEF,
   localparam int FILL_BITS = $clog2(ORDERS + 1),
   localparam int POS_BITS  = $clog2(ORDERS),
   localparam int LVL_BITS  = $clog2(LEVELS),
   localparam int CNT_BITS  = $clog2(LEVELS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptob_pkg::lvl_cmd_type         cmd,
   input  logic [LVL_BITS-1:0]           lvl,
   input  logic [POS_BITS-1:0]           pos,
   input  logic [PRICE_BITS-1:0]         new_price,
   input  logic [ptob_pkg::ID_BITS-1:0]  new_id,
   input  logic [QTY_BITS-1:0]           new_qty,
   output logic [CNT_BITS-1:0]           count,
   output logic [LEVELS-1:0][PRICE_BITS-1:0] prices,
   output logic [LEVELS-1:0][FILL_BITS-1:0]  fills,
   output logic [LEVELS-1:0][ORDERS-1:0][ptob_pkg::ID_BITS-1:0] ids,
   output logic [LEVELS-1:0][ORDERS-1:0][QTY_BITS-1:0] qtys
);
   import ptob_pkg::*;

   logic [CNT_BITS-1:0] count_ff;

   // level count
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd == LC_POP) count_ff <= count_ff - CNT_BITS'(1);
      else if (cmd == LC_INSERT) count_ff <= count_ff + CNT_BITS'(1);
   end
   assign count = count_ff;

   genvar g;
   generate
      for (g = 0; g < LEVELS; g++) begin : g_lvl
         localparam int UP = (g == 0) ? 0 : g - 1;
         localparam int DN = (g == LEVELS - 1) ? g : g + 1;
         logic f_up, f_dn;
         assign f_up = (cmd == LC_INSERT) && (g > int'(lvl));
         assign f_dn = (cmd == LC_POP) && (g >= int'(lvl)) && (g < LEVELS - 1);
         ptob_level_cell #(
            .ORDERS(ORDERS), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)
         ) u_lvl (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .from_up  (f_up),
            .from_down(f_dn),
            .sel      (LVL_BITS'(g) == lvl),
            .pos      (pos),
            .new_price(new_price),
            .new_id   (new_id),
            .new_qty  (new_qty),
            .up_price (prices[UP]),
            .up_fill  (fills[UP]),
            .up_ids   (ids[UP]),
            .up_qtys  (qtys[UP]),
            .dn_price (prices[DN]),
            .dn_fill  ((g == LEVELS - 1) ? FILL_BITS'(0) : fills[DN]),
            .dn_ids   (ids[DN]),
            .dn_qtys  (qtys[DN]),
            .price    (prices[g]),
            .fill     (fills[g]),
            .ids      (ids[g]),
            .qtys     (qtys[g])
         );
      end
   endgenerate

endmodule

// ----- hdl/price_time_order_book_matcher.sv -----
// ----------------------------------------------------------------------------
// price_time_order_book_matcher
// limit order book with price-time matching, built as chains of level cells
// ----------------------------------------------------------------------------
// Usage: req_ words carry add or cancel orders; rsp_ words carry one trade per
// fill and end with a word that has rsp_last set and carries status and the
// best bid and ask. An input is taken only while the block is idle.
// A rejected add goes straight to S_DONE, then to S_OUT to show its last word.
// Each fill passes the steps match, fill, hand-off and output word, and a
// stall holds the output word. A cancel scans one level per cycle, then
// passes a write state and a closing state; resting scans one level per
// cycle, then a write state. Throughput is one item at a time: req_ready
// returns in the cycle after the last rsp_ word is taken.
// A stalled rsp_ready holds the current word in the output register and
// freezes the sequencer. Reset empties both sides of the book; order slots
// are not cleared, since only filled positions are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module price_time_order_book_matcher #(
   parameter int LEVELS           = ptob_pkg::LEVELS_DEF,
   parameter int ORDERS_PER_LEVEL = ptob_pkg::ORDERS_DEF,
   parameter int PRICE_BITS       = ptob_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS         = ptob_pkg::QTY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic        req_side,
   input  logic        req_order_type,
   input  logic [63:0] req_order_id,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_trade_valid,
   output logic [31:0] rsp_trade_price,
   output logic [31:0] rsp_trade_qty,
   output logic [63:0] rsp_buyer_id,
   output logic [63:0] rsp_seller_id,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_best_bid,
   output logic [31:0] rsp_best_ask,
   output logic        rsp_last
);
   import ptob_pkg::*;

   localparam int FILL_BITS = $clog2(ORDERS_PER_LEVEL + 1);
   localparam int POS_BITS  = $clog2(ORDERS_PER_LEVEL);
   localparam int LVL_BITS  = $clog2(LEVELS);
   localparam int CNT_BITS  = $clog2(LEVELS + 1);
   localparam int NB_BITS   = $clog2(MAX_FILLS + 1);
   localparam int PW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
   localparam int QW = (QTY_BITS < 32) ? QTY_BITS : 32;

   typedef enum logic [3:0] {
      S_IDLE, S_MATCH, S_FILL, S_REST_SCAN, S_REST_WR, S_CAN_SCAN, S_CAN_WR,
      S_DONE, S_OUT
   } state_type;

   state_type state_ff;
   logic      side_ff, mkt_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [PRICE_BITS-1:0] price_ff;
   logic [QTY_BITS-1:0]   rem_ff;
   logic [NB_BITS-1:0]    n_ff;
   logic [LVL_BITS-1:0]   lvl_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [CNT_BITS-1:0]   scan_ff;
   logic                  app_ff;    // rest by append rather than insert
   status_type            st_ff;
   logic                  ov_ff;     // output word valid
   logic                  after_ff;  // state after output drains: 1 means back to match
   logic [QTY_BITS-1:0]   fill_q_ff;

   // side buses
   lvl_cmd_type cmd_s [2];
   logic [LVL_BITS-1:0] lvl_s [2];
   logic [POS_BITS-1:0] pos_s [2];
   logic [QTY_BITS-1:0] qty_s [2];
   logic [CNT_BITS-1:0] cnt_s [2];
   logic [LEVELS-1:0][PRICE_BITS-1:0] pr_s [2];
   logic [LEVELS-1:0][FILL_BITS-1:0]  fl_s [2];
   logic [LEVELS-1:0][ORDERS_PER_LEVEL-1:0][ID_BITS-1:0]  id_s [2];
   logic [LEVELS-1:0][ORDERS_PER_LEVEL-1:0][QTY_BITS-1:0] qt_s [2];

   genvar gs;
   generate
      for (gs = 0; gs < 2; gs++) begin : g_side
         ptob_side #(
            .LEVELS(LEVELS), .ORDERS(ORDERS_PER_LEVEL),
            .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)
         ) u_side (
            .clock(clock), .reset(reset), .cmd(cmd_s[gs]), .lvl(lvl_s[gs]),
            .pos(pos_s[gs]), .new_price(price_ff), .new_id(id_ff),
            .new_qty(qty_s[gs]), .count(cnt_s[gs]), .prices(pr_s[gs]),
            .fills(fl_s[gs]), .ids(id_s[gs]), .qtys(qt_s[gs])
         );
      end
   endgenerate

   // views of the opposite best level and of the scanned own level
   logic opp;
   logic [PRICE_BITS-1:0] bp;
   logic [QTY_BITS-1:0]   rr;
   logic [ID_BITS-1:0]    rid;
   logic                  crosses, can_match;
   logic [LVL_BITS-1:0]   scan_lvl;
   logic [PRICE_BITS-1:0] lp;
   logic [FILL_BITS-1:0]  lf;
   logic                  hit_found;
   logic [POS_BITS-1:0]   hit_pos;

   assign opp = ~side_ff;
   assign bp  = pr_s[opp][0];
   assign rr  = qt_s[opp][0][0];
   assign rid = id_s[opp][0][0];
   assign crosses = mkt_ff || (side_ff == 1'b0 ? price_ff >= bp : price_ff <= bp);
   assign can_match = (cnt_s[opp] != '0) && crosses;
   assign scan_lvl = scan_ff[LVL_BITS-1:0];
   assign lp = pr_s[side_ff][scan_lvl];
   assign lf = fl_s[side_ff][scan_lvl];

   // id search inside one level, first match wins
   always_comb begin
      hit_found = 1'b0;
      hit_pos   = '0;
      for (int j = ORDERS_PER_LEVEL - 1; j >= 0; j--) begin
         if (FILL_BITS'(j) < lf && id_s[side_ff][scan_lvl][j] == id_ff) begin
            hit_found = 1'b1;
            hit_pos   = POS_BITS'(j);
         end
      end
   end

   logic [QTY_BITS-1:0] f_qty;
   assign f_qty = (rem_ff < rr) ? rem_ff : rr;

   // side commands
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         cmd_s[s] = LC_NONE;
         lvl_s[s] = '0;
         pos_s[s] = '0;
         qty_s[s] = rem_ff;
      end
      unique case (state_ff)
         S_FILL: begin
            if (rr == fill_q_ff) begin
               if (fl_s[opp][0] == FILL_BITS'(1)) cmd_s[opp] = LC_POP;
               else cmd_s[opp] = LC_HEAD;
            end else begin
               cmd_s[opp] = LC_FILL;
               qty_s[opp] = rr - fill_q_ff;
            end
         end
         S_REST_WR: begin
            cmd_s[side_ff] = app_ff ? LC_APPEND : LC_INSERT;
            lvl_s[side_ff] = lvl_ff;
         end
         S_CAN_WR: begin
            lvl_s[side_ff] = lvl_ff;
            pos_s[side_ff] = pos_ff;
            if (fl_s[side_ff][lvl_ff] == FILL_BITS'(1)) begin
               // removing the only order closes the level, deeper levels move up
               cmd_s[side_ff] = LC_POP;
            end else begin
               cmd_s[side_ff] = LC_REMOVE;
            end
         end
         default: ;
      endcase
   end

   logic [63:0] buyer, seller;
   assign buyer  = side_ff ? rid : id_ff;
   assign seller = side_ff ? id_ff : rid;

   logic [31:0] bb, ba;
   assign bb = (cnt_s[0] != '0) ? 32'(pr_s[0][0][PW-1:0]) : 32'd0;
   assign ba = (cnt_s[1] != '0) ? 32'(pr_s[1][0][PW-1:0]) : 32'd0;

   logic [63:0] o_buy_ff, o_sell_ff;
   logic [31:0] o_px_ff, o_qty_ff;
   logic        o_tv_ff, o_last_ff;

   assign req_ready = (state_ff == S_IDLE);

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  side_ff  <= req_side;
                  mkt_ff   <= req_order_type;
                  id_ff    <= req_order_id;
                  price_ff <= PRICE_BITS'(req_price);
                  rem_ff   <= QTY_BITS'(req_quantity);
                  n_ff     <= '0;
                  scan_ff  <= '0;
                  st_ff    <= ST_OK;
                  o_tv_ff  <= 1'b0;
                  if (req_op) state_ff <= S_CAN_SCAN;
                  else if (QTY_BITS'(req_quantity) == '0) begin
                     st_ff <= ST_BAD_QTY; state_ff <= S_DONE;
                  end else if (!req_order_type && PRICE_BITS'(req_price) == '0) begin
                     st_ff <= ST_BAD_PRICE; state_ff <= S_DONE;
                  end else state_ff <= S_MATCH;
               end
            end
            S_MATCH: begin
               if (rem_ff != '0 && can_match && n_ff < NB_BITS'(MAX_FILLS)) begin
                  // emit the previous trade before starting this one
                  if (o_tv_ff) begin
                     ov_ff <= 1'b1; o_last_ff <= 1'b0; after_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     fill_q_ff <= f_qty;
                     o_px_ff   <= 32'(bp[PW-1:0]);
                     o_qty_ff  <= 32'(f_qty[QW-1:0]);
                     o_buy_ff  <= buyer;
                     o_sell_ff <= seller;
                     state_ff  <= S_FILL;
                  end
               end else if (!mkt_ff && rem_ff != '0 &&
                            !(n_ff == NB_BITS'(MAX_FILLS) && can_match)) begin
                  state_ff <= S_REST_SCAN;
               end else state_ff <= S_DONE;
            end
            S_FILL: begin
               rem_ff   <= rem_ff - fill_q_ff;
               n_ff     <= n_ff + NB_BITS'(1);
               o_tv_ff  <= 1'b1;
               state_ff <= S_MATCH;
            end
            S_REST_SCAN: begin
               if (scan_ff == cnt_s[side_ff]) begin
                  app_ff <= 1'b0; lvl_ff <= scan_lvl;
                  if (cnt_s[side_ff] == CNT_BITS'(LEVELS)) begin
                     st_ff <= ST_FULL; state_ff <= S_DONE;
                  end else state_ff <= S_REST_WR;
               end else if (lp == price_ff) begin
                  app_ff <= 1'b1; lvl_ff <= scan_lvl;
                  if (lf == FILL_BITS'(ORDERS_PER_LEVEL)) begin
                     st_ff <= ST_FULL; state_ff <= S_DONE;
                  end else state_ff <= S_REST_WR;
               end else if (side_ff == 1'b0 ? lp < price_ff : lp > price_ff) begin
                  app_ff <= 1'b0; lvl_ff <= scan_lvl;
                  if (cnt_s[side_ff] == CNT_BITS'(LEVELS)) begin
                     st_ff <= ST_FULL; state_ff <= S_DONE;
                  end else state_ff <= S_REST_WR;
               end else scan_ff <= scan_ff + CNT_BITS'(1);
            end
            S_REST_WR: state_ff <= S_DONE;
            S_CAN_SCAN: begin
               if (scan_ff == cnt_s[side_ff]) begin
                  st_ff <= ST_NOT_FOUND; state_ff <= S_DONE;
               end else if (hit_found) begin
                  lvl_ff <= scan_lvl; pos_ff <= hit_pos; state_ff <= S_CAN_WR;
               end else scan_ff <= scan_ff + CNT_BITS'(1);
            end
            S_CAN_WR: state_ff <= S_DONE;
            S_DONE: begin
               ov_ff <= 1'b1; o_last_ff <= 1'b1; after_ff <= 1'b0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  ov_ff <= 1'b0;
                  o_tv_ff <= 1'b0;
                  state_ff <= after_ff ? S_MATCH : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_trade_valid = o_tv_ff;
   assign rsp_trade_price = o_tv_ff ? o_px_ff : 32'd0;
   assign rsp_trade_qty   = o_tv_ff ? o_qty_ff : 32'd0;
   assign rsp_buyer_id    = o_tv_ff ? o_buy_ff : 64'd0;
   assign rsp_seller_id   = o_tv_ff ? o_sell_ff : 64'd0;
   assign rsp_last        = o_last_ff;
   assign rsp_status      = o_last_ff ? st_ff : 3'd0;
   assign rsp_best_bid    = o_last_ff ? bb : 32'd0;
   assign rsp_best_ask    = o_last_ff ? ba : 32'd0;

   `ASSERT_CLK(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> !req_ready, "busy accept")
   `ASSERT_CLK(a_out_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "word dropped")
   `ASSERT_CLK(a_cnt_range, clock, reset, cnt_s[0] <= CNT_BITS'(LEVELS), "level count overflow")

endmodule

// ----- dv/tb_price_time_order_book_matcher.sv -----
// ----------------------------------------------------------------------------
// tb_price_time_order_book_matcher
// drives add and cancel words into the order book, predicts trades and the
// closing status word with a behavioral book, and checks every rsp_ word
// ----------------------------------------------------------------------------
module tb_price_time_order_book_matcher;
   import ptob_pkg::*;

   localparam int NLVL = 8;
   localparam int NORD = 8;

   typedef struct {
      logic        op;
      logic        side;
      logic        mkt;
      logic [63:0] id;
      logic [31:0] price;
      logic [31:0] qty;
   } order_word_type;

   typedef struct {
      logic        tv;
      logic [31:0] tpx;
      logic [31:0] tqty;
      logic [63:0] buyer;
      logic [63:0] seller;
      logic [2:0]  status;
      logic [31:0] bid;
      logic [31:0] ask;
      logic        last;
   } book_word_type;

   // directed row: stimulus plus optional typed-in closing word
   typedef struct {
      order_word_type w;
      bit             typed;
      book_word_type  exp;
   } dir_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_op = 0, req_side = 0, req_order_type = 0;
   logic [63:0] req_order_id = 0;
   logic [31:0] req_price = 0, req_quantity = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_trade_valid, rsp_last;
   logic [31:0] rsp_trade_price, rsp_trade_qty, rsp_best_bid, rsp_best_ask;
   logic [63:0] rsp_buyer_id, rsp_seller_id;
   logic [2:0]  rsp_status;

   price_time_order_book_matcher dut (.*);

   always #1 clock = ~clock;

   // predictor copy of the book: levels sorted best first, fifo kept as queue
   logic [31:0] bk_px [2][NLVL];
   int          bk_cnt [2];
   logic [63:0] bk_id [2][NLVL][$];
   logic [31:0] bk_rem [2][NLVL][$];

   book_word_type expected_words[$];
   int errors = 0;
   int n_words = 0, fill_words = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_off = 0;

   function automatic book_word_type blank_word();
      book_word_type b;
      b = '{default: 0};
      return b;
   endfunction

   function automatic void drop_level(int s, int i);
      for (int k = i; k + 1 < bk_cnt[s]; k++) begin
         bk_px[s][k] = bk_px[s][k+1];
         bk_id[s][k] = bk_id[s][k+1];
         bk_rem[s][k] = bk_rem[s][k+1];
      end
      bk_cnt[s]--;
      bk_id[s][bk_cnt[s]] = {};
      bk_rem[s][bk_cnt[s]] = {};
   endfunction

   function automatic status_type rest_order(int s, logic [63:0] id, logic [31:0] px,
                                             logic [31:0] q);
      int pos;
      pos = 0;
      while (pos < bk_cnt[s]) begin
         if (bk_px[s][pos] == px) begin
            if (bk_id[s][pos].size() >= NORD) return ST_FULL;
            bk_id[s][pos].push_back(id);
            bk_rem[s][pos].push_back(q);
            return ST_OK;
         end
         if (s == 0 ? bk_px[s][pos] < px : bk_px[s][pos] > px) break;
         pos++;
      end
      if (bk_cnt[s] >= NLVL) return ST_FULL;
      for (int k = bk_cnt[s]; k > pos; k--) begin
         bk_px[s][k] = bk_px[s][k-1];
         bk_id[s][k] = bk_id[s][k-1];
         bk_rem[s][k] = bk_rem[s][k-1];
      end
      bk_px[s][pos] = px;
      bk_id[s][pos] = {id};
      bk_rem[s][pos] = {q};
      bk_cnt[s]++;
      return ST_OK;
   endfunction

   function automatic bit price_crosses(int s, logic mkt, logic [31:0] px, logic [31:0] best);
      if (mkt) return 1;
      return s == 0 ? px >= best : px <= best;
   endfunction

   // run one word through the book and queue the words it causes
   function automatic void match_order(order_word_type w);
      book_word_type r;
      status_type st;
      logic [31:0] rem, f;
      int n, s, opp;
      s = w.side;
      opp = s ^ 1;
      n = 0;
      st = ST_OK;
      if (w.op) begin
         st = ST_NOT_FOUND;
         for (int i = 0; i < bk_cnt[s] && st != ST_OK; i++)
            for (int j = 0; j < bk_id[s][i].size(); j++)
               if (bk_id[s][i][j] == w.id) begin
                  bk_id[s][i].delete(j);
                  bk_rem[s][i].delete(j);
                  if (bk_id[s][i].size() == 0) drop_level(s, i);
                  st = ST_OK;
                  break;
               end
      end else if (w.qty == 0) st = ST_BAD_QTY;
      else if (!w.mkt && w.price == 0) st = ST_BAD_PRICE;
      else begin
         rem = w.qty;
         while (rem != 0 && bk_cnt[opp] > 0 && n < MAX_FILLS) begin
            if (!price_crosses(s, w.mkt, w.price, bk_px[opp][0])) break;
            while (rem != 0 && bk_id[opp][0].size() > 0 && n < MAX_FILLS) begin
               f = rem < bk_rem[opp][0][0] ? rem : bk_rem[opp][0][0];
               rem -= f;
               bk_rem[opp][0][0] -= f;
               r = blank_word();
               r.tv = 1;
               r.tpx = bk_px[opp][0];
               r.tqty = f;
               r.buyer = s == 0 ? w.id : bk_id[opp][0][0];
               r.seller = s == 0 ? bk_id[opp][0][0] : w.id;
               expected_words.push_back(r);
               n++;
               if (bk_rem[opp][0][0] == 0) begin
                  void'(bk_id[opp][0].pop_front());
                  void'(bk_rem[opp][0].pop_front());
               end
            end
            if (bk_id[opp][0].size() == 0) drop_level(opp, 0);
         end
         if (!w.mkt && rem != 0)
            if (!(n >= MAX_FILLS && bk_cnt[opp] > 0 &&
                  price_crosses(s, w.mkt, w.price, bk_px[opp][0])))
               st = rest_order(s, w.id, w.price, rem);
      end
      if (n == 0) expected_words.push_back(blank_word());
      r = expected_words.pop_back();
      r.status = st;
      r.bid = bk_cnt[0] ? bk_px[0][0] : 0;
      r.ask = bk_cnt[1] ? bk_px[1][0] : 0;
      r.last = 1;
      expected_words.push_back(r);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("error: word %0d field %s got %0h expected %0h", n_words, what, got, want);
      errors++;
   endtask

   // send one word and wait for acceptance; valid stays up for the next word
   task automatic send_word(order_word_type w);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= w.op;
      req_side <= w.side;
      req_order_type <= w.mkt;
      req_order_id <= w.id;
      req_price <= w.price;
      req_quantity <= w.qty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      match_order(w);
   endtask

   // receiver: random stalls plus a long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
   end

   // result checker
   always @(posedge clock) begin
      book_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            e = expected_words.pop_front();
            if (rsp_trade_valid !== e.tv) report_mismatch("trade_valid", rsp_trade_valid, e.tv);
            if (rsp_trade_price !== e.tpx) report_mismatch("trade_price", rsp_trade_price, e.tpx);
            if (rsp_trade_qty !== e.tqty) report_mismatch("trade_qty", rsp_trade_qty, e.tqty);
            if (rsp_buyer_id !== e.buyer) report_mismatch("buyer_id", rsp_buyer_id, e.buyer);
            if (rsp_seller_id !== e.seller) report_mismatch("seller_id", rsp_seller_id, e.seller);
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_best_bid !== e.bid) report_mismatch("best_bid", rsp_best_bid, e.bid);
            if (rsp_best_ask !== e.ask) report_mismatch("best_ask", rsp_best_ask, e.ask);
            if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
         end
         if (rsp_trade_valid) fill_words++;
         n_words++;
      end
   end

   function automatic order_word_type mk(logic op, logic s, logic m, logic [63:0] id,
                                         logic [31:0] px, logic [31:0] q);
      order_word_type w;
      w.op = op; w.side = s; w.mkt = m; w.id = id; w.price = px; w.qty = q;
      return w;
   endfunction

   function automatic dir_row_type row(order_word_type w);
      dir_row_type d;
      d.w = w;
      d.typed = 0;
      d.exp = blank_word();
      return d;
   endfunction

   function automatic dir_row_type row_st(order_word_type w, status_type st, logic [31:0] bid,
                                          logic [31:0] ask);
      dir_row_type d;
      d = row(w);
      d.typed = 1;
      d.exp.status = st;
      d.exp.bid = bid;
      d.exp.ask = ask;
      d.exp.last = 1;
      return d;
   endfunction

   // random word: mostly limit orders around a narrow band so they cross
   function automatic order_word_type rand_word(int phase);
      order_word_type w;
      logic [63:0] id;
      int kind;
      kind = $urandom_range(99);
      id = phase % 2 ? {$urandom, $urandom} : 64'($urandom_range(40));
      w = mk(0, 1'($urandom_range(1)), 0, id, 32'(100 + $urandom_range(12)),
             32'($urandom_range(1, 30)));
      if (kind < 15) w.op = 1;
      else if (kind < 25) w.mkt = 1;
      else if (kind < 29) w.qty = 0;
      else if (kind < 32) w.price = 0;
      else if (kind < 36) begin
         w.price = $urandom;
         w.qty = $urandom;
      end else if (kind < 38) w.mkt = 1'($urandom_range(1));
      if (kind >= 38 && kind < 40) w.qty = 32'hFFFF_FFFF;
      return w;
   endfunction

   initial begin
      dir_row_type dirs[$];
      book_word_type e;
      int wait_cnt;
      // directed table
      dirs.push_back(row_st(mk(0, 0, 0, 1, 100, 0), ST_BAD_QTY, 0, 0));
      dirs.push_back(row_st(mk(0, 1, 0, 2, 0, 5), ST_BAD_PRICE, 0, 0));
      dirs.push_back(row_st(mk(1, 0, 0, 3, 0, 0), ST_NOT_FOUND, 0, 0));
      dirs.push_back(row_st(mk(0, 1, 1, 4, 0, 5), ST_OK, 0, 0));
      dirs.push_back(row_st(mk(0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                            ST_OK, 32'hFFFF_FFFF, 0));
      dirs.push_back(row_st(mk(0, 1, 0, 5, 1, 1), ST_OK, 32'hFFFF_FFFF, 0));
      dirs.push_back(row(mk(0, 1, 1, 6, 32'hFFFF_FFFF, 7)));
      dirs.push_back(row_st(mk(1, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                            ST_OK, 0, 0));
      for (int i = 0; i < 9; i++) dirs.push_back(row(mk(0, 1, 0, 10 + i, 50 + i, 2)));
      for (int i = 0; i < 9; i++) dirs.push_back(row(mk(0, 1, 0, 30 + i, 50, 1)));
      dirs.push_back(row(mk(1, 1, 0, 31, 0, 0)));
      dirs.push_back(row(mk(0, 0, 0, 7, 55, 100)));
      dirs.push_back(row(mk(0, 0, 1, 8, 0, 32'hFFFF_FFFF)));

      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dirs[i]) begin
         send_word(dirs[i].w);
         if (dirs[i].typed) begin
            e = expected_words[$];
            if (e.status !== dirs[i].exp.status || e.bid !== dirs[i].exp.bid ||
                e.ask !== dirs[i].exp.ask)
               report_mismatch("directed row", i, e.status);
         end
      end

      // many fills from one order: build 64+ resting lots then sweep
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 8; j++) send_word(mk(0, 0, 0, 200 + i * 8 + j, 20 - i, 1));
      send_word(mk(0, 1, 0, 300, 1, 100));

      // random phases with different idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0; recv_idle = 0; end
            1: begin send_idle = 50; recv_idle = 0; end
            2: begin send_idle = 0; recv_idle = 50; end
            default: begin send_idle = 6; recv_idle = 6; end
         endcase
         if (ph == 2) begin
            fork
               begin
                  hold_off = 1;
                  wait_cnt = 0;
                  while (wait_cnt < 300) begin
                     @(posedge clock);
                     wait_cnt++;
                  end
                  hold_off = 0;
               end
            join_none
         end
         for (int i = 0; i < 30; i++) send_word(rand_word(ph));
      end
      req_valid <= 0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d result words with %0d trades over directed rows and four",
               n_words, fill_words);
      $display("idling phases including a long receiver hold-off");
      if (errors == 0 && expected_words.size() == 0)
         $display("price_time_order_book_matcher: match");
      else
         $display("price_time_order_book_matcher: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("price_time_order_book_matcher: mismatch");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ptob_pkg.sv
hdl/ptob_order_cell.sv
hdl/ptob_level_cell.sv
hdl/ptob_side.sv
hdl/price_time_order_book_matcher.sv
dv/tb_price_time_order_book_matcher.sv
